>>> src/mtam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtam_pkg;

    typedef struct packed {
        logic               mode;
        logic [1:0]         slot;
        logic signed [15:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic               last_of_frame;
    } out_item_t;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_PULL = 1'b1;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_MASK   = 3'd1;
    localparam logic [2:0] CFG_SELF   = 3'd2;
    localparam logic [2:0] CFG_VOL0   = 3'd3;
    localparam logic [2:0] CFG_VOL1   = 3'd4;
    localparam logic [2:0] CFG_VOL2   = 3'd5;
    localparam logic [2:0] CFG_VOL3   = 3'd6;

    localparam int REG_SLOTS = 4;
    localparam logic signed [19:0] SAT_HI = 20'sd32767;
    localparam logic signed [19:0] SAT_LO = -20'sd32768;
    localparam int PERCENT = 100;

endpackage
`default_nettype wire

>>> src/mtam_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mtam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

>>> src/mtam_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front: accepts transactions into a two-entry queue.
module mtam_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mtam_pkg::in_item_t s_data,
    output logic                    q_valid,
    input  wire logic               q_pop,
    output mtam_pkg::in_item_t      q_data
);
    import mtam_pkg::*;

    in_item_t   ent_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_data  = ent_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) ent_reg[wr_reg] <= s_data;
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue count overflow");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2 && !pop) |=> !s_ready) else $error("full not held");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop on empty");
endmodule
`default_nettype wire

>>> src/mtam_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back: pushes write the rings; pulls walk slots one per step and divide when two or more mix.
module mtam_back #(
    parameter int MEMBERS    = 4,
    parameter int RING_DEPTH = 2048,
    parameter int FRAME_LEN  = 320
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire mtam_pkg::in_item_t q_data,
    input  wire logic               audio_enable,
    input  wire logic [3:0]         member_mask,
    input  wire logic [1:0]         self_slot,
    input  wire logic [31:0]        volumes,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mtam_pkg::out_item_t     m_data
);
    import mtam_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int SW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
    localparam int AW = $clog2(MEMBERS * RING_DEPTH);
    localparam int FW = $clog2(FRAME_LEN + 1);
    localparam int NS = (MEMBERS < REG_SLOTS) ? MEMBERS : REG_SLOTS;
    localparam int CW = $clog2(NS + 1);
    // ceil(2^30 / 100); floor(m * RECIP_100 / 2^30) == m / 100 for m < 2^23
    localparam logic [23:0] RECIP_100 = 24'd10737419;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_READ, ST_MUL, ST_SCALE, ST_ACC, ST_DIV, ST_OUT
    } state_t;

    state_t            state_reg;
    logic [PW-1:0]     wp_reg [MEMBERS];
    logic [PW-1:0]     rp_reg [MEMBERS];
    logic [FW-1:0]     fpos_reg;
    logic [NS-1:0]     active_reg;
    logic              audible_reg;
    logic [SW-1:0]     idx_reg;
    logic signed [19:0] acc_reg;
    logic signed [24:0] prod_reg;
    logic signed [17:0] term_reg;
    logic [CW-1:0]     cnt_reg;
    logic [16:0]       mag_reg;
    logic [16:0]       quo_reg;
    logic [CW+16:0]    rem_reg;
    logic [4:0]        bit_reg;
    logic              neg_reg;
    logic              last_c;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [15:0]       ram_rdata;

    logic              is_push;
    logic [SW-1:0]     push_slot;

    assign is_push   = q_valid && (q_data.mode == MODE_PUSH);
    assign push_slot = SW'(q_data.slot);
    assign ram_we    = (state_reg == ST_IDLE) && is_push && (32'(q_data.slot) < MEMBERS);
    assign ram_waddr = AW'(push_slot) * AW'(RING_DEPTH) + AW'(wp_reg[push_slot]);
    assign ram_raddr = AW'(idx_reg) * AW'(RING_DEPTH) + AW'(rp_reg[idx_reg]);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid &&
                       (is_push || !m_valid || m_ready);
    assign last_c    = (32'(fpos_reg) + 1 >= FRAME_LEN);

    mtam_ram #(.WIDTH(16), .DEPTH(MEMBERS * RING_DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(q_data.sample_in),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (32'(p) + 1 >= RING_DEPTH) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW:0] fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
        return (w >= r) ? {1'b0, w - r} : {1'b0, w} + (PW+1)'(RING_DEPTH) - {1'b0, r};
    endfunction

    logic [NS-1:0] act_c;
    logic          aud_c;
    logic [CW-1:0] pop_c;
    always_comb begin
        aud_c = audio_enable && ($countones(member_mask) >= 2);
        act_c = '0;
        for (int s = 0; s < NS; s++) begin
            if (aud_c && member_mask[s] && (2'(s) != self_slot) &&
                (32'(fill(wp_reg[s], rp_reg[s])) >= FRAME_LEN))
                act_c[s] = 1'b1;
        end
        pop_c = CW'($countones(act_c));
    end

    // Divide by 100 on the magnitude, so the quotient truncates toward zero.
    logic [22:0]        pmag_c;
    logic [46:0]        qprod_c;
    logic [16:0]        qmag_c;
    logic signed [17:0] term_c;
    logic signed [19:0] sum_c;
    logic [CW+16:0]     trial_c;
    always_comb begin
        pmag_c  = prod_reg[24] ? 23'(-prod_reg) : 23'(prod_reg);
        qprod_c = 47'(pmag_c) * 47'(RECIP_100);
        qmag_c  = qprod_c[46:30];
        term_c  = prod_reg[24] ? -$signed({1'b0, qmag_c}) : $signed({1'b0, qmag_c});
        sum_c   = acc_reg + 20'(term_reg);
        if (sum_c > SAT_HI) sum_c = SAT_HI;
        else if (sum_c < SAT_LO) sum_c = SAT_LO;
        trial_c = {rem_reg[CW+15:0], mag_reg[16]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fpos_reg    <= '0;
            active_reg  <= '0;
            audible_reg <= 1'b0;
            m_valid     <= 1'b0;
            for (int s = 0; s < MEMBERS; s++) begin
                wp_reg[s] <= '0;
                rp_reg[s] <= '0;
            end
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        if (is_push) begin
                            if (ram_we) wp_reg[push_slot] <= nxt(wp_reg[push_slot]);
                        end else begin
                            acc_reg  <= '0;
                            idx_reg  <= '0;
                            state_reg <= ST_SCAN;
                            if (fpos_reg == '0) begin
                                audible_reg <= aud_c;
                                active_reg  <= act_c;
                                cnt_reg     <= pop_c;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (!audible_reg) begin
                        state_reg <= ST_OUT;
                    end else if (32'(idx_reg) < NS && active_reg[idx_reg]) begin
                        state_reg <= ST_READ;
                    end else if (32'(idx_reg) >= NS - 1) begin
                        state_reg <= ST_DIV;
                        neg_reg <= acc_reg[19];
                        mag_reg <= acc_reg[19] ? 17'(-acc_reg) : 17'(acc_reg);
                        rem_reg <= '0;
                        bit_reg <= 5'd17;
                    end else begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                ST_READ: state_reg <= ST_MUL;
                ST_MUL: begin
                    prod_reg  <= $signed(ram_rdata) *
                                 $signed({1'b0, volumes[8*idx_reg +: 8]});
                    rp_reg[idx_reg] <= nxt(rp_reg[idx_reg]);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    term_reg  <= term_c;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg <= sum_c;
                    if (32'(idx_reg) >= NS - 1) begin
                        state_reg <= ST_DIV;
                        neg_reg <= sum_c[19];
                        mag_reg <= sum_c[19] ? 17'(-sum_c) : 17'(sum_c);
                        rem_reg <= '0;
                        bit_reg <= 5'd17;
                    end else begin
                        idx_reg <= idx_reg + SW'(1);
                        state_reg <= ST_SCAN;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg < CW'(2)) begin
                        state_reg <= ST_OUT;
                    end else if (bit_reg == 5'd0) begin
                        acc_reg <= neg_reg ? -20'(quo_reg) : 20'(quo_reg);
                        state_reg <= ST_OUT;
                    end else begin
                        mag_reg <= {mag_reg[15:0], 1'b0};
                        if (trial_c >= (CW+17)'(cnt_reg)) begin
                            rem_reg <= trial_c - (CW+17)'(cnt_reg);
                            quo_reg <= {quo_reg[15:0], 1'b1};
                        end else begin
                            rem_reg <= trial_c;
                            quo_reg <= {quo_reg[15:0], 1'b0};
                        end
                        bit_reg <= bit_reg - 5'd1;
                    end
                end
                ST_OUT: begin
                    m_data.mixed_sample  <= audible_reg ? acc_reg[15:0] : 16'sd0;
                    m_data.last_of_frame <= last_c;
                    fpos_reg <= last_c ? '0 : fpos_reg + FW'(1);
                    m_valid  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_outhold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (!m_valid || m_ready)) else $error("output overrun");
    a_fpos: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fpos_reg) < FRAME_LEN) else $error("frame position range");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> state_reg == ST_IDLE) else $error("pop while busy");
endmodule
`default_nettype wire

>>> src/multi_talker_audio_mixer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Push transaction: queued, then written into its ring by the back end.
// Pull transaction, accept to result valid: reads, scales and adds each active slot,
// then a 17-step count divide when two or more slots mix; silent frames skip both.
// Throughput is set by the back-end slot walk, the bit-serial divider and output back-pressure.
// Reset (aresetn low, synchronous): pointers, frame state, queue cleared;
// config registers reset; ring contents stay undefined until written.
module multi_talker_audio_mixer_unit #(
    parameter int MEMBERS    = 4,
    parameter int RING_DEPTH = 2048,
    parameter int FRAME_LEN  = 320
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mtam_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mtam_pkg::out_item_t      m_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);
    import mtam_pkg::*;

    // Configuration registers.
    logic        enable_reg;
    logic [3:0]  mask_reg;
    logic [1:0]  self_reg;
    logic [31:0] vol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            mask_reg   <= 4'd0;
            self_reg   <= 2'd0;
            vol_reg    <= {4{8'(PERCENT)}};
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE: enable_reg <= cfg_data[0];
                CFG_MASK:   mask_reg   <= cfg_data[3:0];
                CFG_SELF:   self_reg   <= cfg_data[1:0];
                CFG_VOL0:   vol_reg[7:0]   <= cfg_data;
                CFG_VOL1:   vol_reg[15:8]  <= cfg_data;
                CFG_VOL2:   vol_reg[23:16] <= cfg_data;
                CFG_VOL3:   vol_reg[31:24] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Queue between front and back carries one transaction per entry.
    logic     q_valid, q_pop;
    in_item_t q_data;

    mtam_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    mtam_back #(.MEMBERS(MEMBERS), .RING_DEPTH(RING_DEPTH), .FRAME_LEN(FRAME_LEN)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_pop(q_pop),
        .q_data(q_data), .audio_enable(enable_reg), .member_mask(mask_reg),
        .self_slot(self_reg), .volumes(vol_reg), .m_valid(m_valid),
        .m_ready(m_ready), .m_data(m_data)
    );
endmodule
`default_nettype wire

>>> tb/mix_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Watches both channels and the register port, predicts each mixed sample
// and compares it with what the mixer returns.
module mix_checker
    import mtam_pkg::*;
#(
    parameter int MEMBERS    = 4,
    parameter int RING_DEPTH = 2048,
    parameter int FRAME_LEN  = 320
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    input  wire logic      cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output int             fail_count,
    output int             samples_owed
);

    logic signed [15:0] ring_mem [MEMBERS][RING_DEPTH];
    int        wr_ptr [MEMBERS];
    int        rd_ptr [MEMBERS];
    int        frame_pos;
    logic [3:0] frame_slots;
    logic      frame_on;

    logic       en_reg;
    logic [3:0] mask_reg;
    logic [1:0] self_reg;
    logic [7:0] vol_reg [REG_SLOTS];

    out_item_t owed_q [$];

    function automatic int ring_level(int s);
        return (wr_ptr[s] - rd_ptr[s] + RING_DEPTH) % RING_DEPTH;
    endfunction

    task automatic mix_one(output out_item_t res);
        int acc;
        int term;
        int cnt;
        if (frame_pos == 0) begin
            frame_on = en_reg && ($countones(mask_reg) >= 2);
            frame_slots = '0;
            if (frame_on) begin
                for (int s = 0; s < MEMBERS && s < REG_SLOTS; s++) begin
                    if (mask_reg[s] && s != int'(self_reg) && ring_level(s) >= FRAME_LEN)
                        frame_slots[s] = 1'b1;
                end
            end
        end
        acc = 0;
        if (frame_on) begin
            for (int s = 0; s < MEMBERS && s < REG_SLOTS; s++) begin
                if (frame_slots[s]) begin
                    term = (int'(ring_mem[s][rd_ptr[s]]) * int'(vol_reg[s])) / PERCENT;
                    acc = acc + term;
                    if (acc > 32767) acc = 32767;
                    if (acc < -32768) acc = -32768;
                    rd_ptr[s] = (rd_ptr[s] + 1) % RING_DEPTH;
                end
            end
            cnt = $countones(frame_slots);
            if (cnt >= 2) acc = acc / cnt;
        end
        frame_pos++;
        res.last_of_frame = (frame_pos >= FRAME_LEN);
        if (res.last_of_frame) frame_pos = 0;
        res.mixed_sample = acc[15:0];
    endtask

    always @(posedge aclk) begin
        out_item_t res;
        out_item_t want;
        if (!aresetn) begin
            for (int s = 0; s < MEMBERS; s++) begin
                wr_ptr[s] = 0;
                rd_ptr[s] = 0;
            end
            frame_pos = 0;
            frame_slots = '0;
            frame_on = 1'b0;
            en_reg = 1'b0;
            mask_reg = '0;
            self_reg = '0;
            for (int s = 0; s < REG_SLOTS; s++) vol_reg[s] = 8'(PERCENT);
            owed_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ENABLE: en_reg = cfg_data[0];
                    CFG_MASK:   mask_reg = cfg_data[3:0];
                    CFG_SELF:   self_reg = cfg_data[1:0];
                    CFG_VOL0:   vol_reg[0] = cfg_data;
                    CFG_VOL1:   vol_reg[1] = cfg_data;
                    CFG_VOL2:   vol_reg[2] = cfg_data;
                    CFG_VOL3:   vol_reg[3] = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_data.mode == MODE_PUSH) begin
                    if (int'(s_data.slot) < MEMBERS) begin
                        ring_mem[s_data.slot][wr_ptr[s_data.slot]] = s_data.sample_in;
                        wr_ptr[s_data.slot] = (wr_ptr[s_data.slot] + 1) % RING_DEPTH;
                    end
                end else begin
                    mix_one(res);
                    owed_q.push_back(res);
                end
            end
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $error("unexpected mixed sample %0d", m_data.mixed_sample);
                    fail_count++;
                end else begin
                    want = owed_q.pop_front();
                    if (m_data.mixed_sample !== want.mixed_sample) begin
                        $error("mixed_sample: expected %0d, got %0d",
                               want.mixed_sample, m_data.mixed_sample);
                        fail_count++;
                    end
                    if (m_data.last_of_frame !== want.last_of_frame) begin
                        $error("last_of_frame: expected %0d, got %0d",
                               want.last_of_frame, m_data.last_of_frame);
                        fail_count++;
                    end
                end
            end
        end
        samples_owed = owed_q.size();
    end

    initial fail_count = 0;
    initial samples_owed = 0;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
// Stimulus and verdict for the mixer. After a directed start, each phase
// programs the registers while the mixer is idle, fills the rings it picks
// with voice, then pulls toward the frame end with some pushes mixed in.
module testbench;
    import mtam_pkg::*;

    localparam int FRAME_LEN  = 320;
    localparam int RING_DEPTH = 2048;
    localparam int TIMEOUT    = 4000000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int fail_count;
    int samples_owed;
    int cycle_count;
    int pulls_sent;
    int hold_request;   // long receiver hold-off, consumed by the receiver
    int hold_left;
    bit no_idle;        // stretch with no gaps on either side

    multi_talker_audio_mixer_unit #(
        .MEMBERS(4), .RING_DEPTH(RING_DEPTH), .FRAME_LEN(FRAME_LEN)
    ) i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready,
        .m_data, .cfg_we, .cfg_index, .cfg_data
    );

    mix_checker #(.MEMBERS(4), .RING_DEPTH(RING_DEPTH), .FRAME_LEN(FRAME_LEN)) i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready,
        .m_data, .cfg_we, .cfg_index, .cfg_data, .fail_count, .samples_owed
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stall after each transaction, plus the long hold-off
    // requested by the stimulus so the mixer backs up into its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= (hold_left == 0);
        end else if (m_valid && m_ready) begin
            hold_left = no_idle ? 0 : $urandom_range(0, 14);
            m_ready <= (hold_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send(input in_item_t item);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (item.mode == MODE_PULL) pulls_sent++;
    endtask

    function automatic logic signed [15:0] voice_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push(input int slot, input logic signed [15:0] smp);
        in_item_t item;
        item.mode = MODE_PUSH;
        item.slot = 2'(slot);
        item.sample_in = smp;
        send(item);
    endtask

    task automatic pull();
        in_item_t item;
        item.mode = MODE_PULL;
        item.slot = 2'($urandom);
        item.sample_in = 16'($urandom);
        send(item);
    endtask

    // Quiet the input, drain every owed sample, then let queued pushes retire.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (samples_owed != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Write enable stays high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic en, input logic [3:0] mask, input logic [1:0] self_id,
                                input logic [7:0] v0, input logic [7:0] v1,
                                input logic [7:0] v2, input logic [7:0] v3);
        write_reg(CFG_ENABLE, {7'd0, en});
        write_reg(CFG_MASK, {4'd0, mask});
        write_reg(CFG_SELF, {6'd0, self_id});
        write_reg(CFG_VOL0, v0);
        write_reg(CFG_VOL1, v1);
        write_reg(CFG_VOL2, v2);
        write_reg(CFG_VOL3, v3);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] rand_volume();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd100;
            default: return 8'($urandom);
        endcase
    endfunction

    // Fill the chosen rings, interleaved in random slot order, then send items
    // matching the pulls the frame lacks (plus a frame if few), some as pushes.
    task automatic voice_phase(input logic [3:0] fill_slots);
        int left [4];
        int total;
        int s;
        int npull;
        total = 0;
        for (int k = 0; k < 4; k++) begin
            left[k] = fill_slots[k] ? FRAME_LEN + $urandom_range(0, 16) : 0;
            total += left[k];
        end
        while (total > 0) begin
            s = $urandom_range(0, 3);
            if (left[s] > 0) begin
                push(s, voice_sample());
                left[s]--;
                total--;
            end
        end
        npull = FRAME_LEN - (pulls_sent % FRAME_LEN);
        if (npull < FRAME_LEN / 2) npull += FRAME_LEN;
        for (int k = 0; k < npull; k++) begin
            if ($urandom_range(0, 9) == 0) push($urandom_range(0, 3), voice_sample());
            else pull();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        cycle_count = 0;
        pulls_sent = 0;
        hold_request = 0;
        hold_left = 0;
        no_idle = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extreme samples into every slot, silent pulls while mixing
        // is disabled at reset.
        for (int s = 0; s < 4; s++) begin
            push(s, 16'sh7FFF);
            push(s, 16'sh8000);
            push(s, 16'sh0000);
            push(s, 16'shFFFF);
        end
        repeat (4) pull();
        wait_idle();

        // Disabled: two rings fill while the frame stays silent, read
        // pointers must stay put.
        program_regs(1'b0, 4'hF, 2'd3, 8'd0, 8'd100, 8'd255, 8'd1);
        voice_phase(4'h3);
        wait_idle();

        // Two active talkers at full gain, saturation and divide by two;
        // receiver holds off while pulls keep coming.
        program_regs(1'b1, 4'hB, 2'd3, 8'd255, 8'd255, 8'd37, 8'd200);
        hold_request = 3000;
        voice_phase(4'h0);
        wait_idle();

        // Random registers, no idling on either side.
        no_idle = 1'b1;
        program_regs(($urandom_range(0, 5) != 0), 4'($urandom), 2'($urandom),
                     rand_volume(), rand_volume(), rand_volume(), rand_volume());
        voice_phase(4'h0);
        wait_idle();
        no_idle = 1'b0;

        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
src/mtam_pkg.sv
src/mtam_ram.sv
src/mtam_front.sv
src/mtam_back.sv
src/multi_talker_audio_mixer_unit.sv
tb/mix_checker.sv
tb/testbench.sv
